// ===== rtl/dcs_pkg.sv =====
// Shared types and constants for the divisor count and sum block.
`default_nettype none

package dcs_pkg;

  localparam int COUNT_W = 11;
  localparam int SUM_W   = 36;
  localparam int MUL_W   = 36;

  localparam logic [MUL_W-1:0] COUNT_MAX = 36'd2047;
  localparam logic [MUL_W-1:0] SUM_MAX   = {MUL_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIV_WAIT,
    S_PK_MUL,
    S_PK_WAIT,
    S_CNT_MUL,
    S_CNT_WAIT,
    S_SUM_MUL,
    S_SUM_WAIT,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

// ===== rtl/divisor_count_and_sum.sv =====
// Top level: divisor count and divisor sum by serial trial division.
//
// Request: drive value and pulse start while busy is low; the request is taken
// at that edge and busy rises. Only bits below VALUE_WIDTH of value are used.
// Result: divisor_count and divisor_sum are valid for the single cycle in
// which done is high; busy drops the cycle after. The receiver cannot stall.
// A zero value returns count 0 and sum 0.
// Search: trial divisors 2 and then every odd number are tried while d*d is
// at most the remaining value; each trial is one pass of the bit-serial divider.
// Each prime power found adds a divide and a serial multiply per exponent step,
// and two serial multiplies per prime. Worst case for 32-bit values is about
// 32768 trials.
// One request is in flight at a time.
// Reset: synchronous rst returns the block to idle; no result is pending.
`default_nettype none

module divisor_count_and_sum #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [10:0]      divisor_count,
  output logic [35:0]      divisor_sum
);

  localparam int MW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int EW = $clog2(MW + 2);
  localparam int MUL_W = dcs_pkg::MUL_W;

  dcs_pkg::state_t state, state_next;

  logic [MW-1:0]                  m;
  logic [MW-1:0]                  d;
  logic [MW+1:0]                  sq;
  logic [EW-1:0]                  e1;
  logic [MUL_W-1:0]               pk;
  logic [MW:0]                    s;
  logic [dcs_pkg::COUNT_W-1:0]    count;
  logic [dcs_pkg::SUM_W-1:0]      sum;
  logic                           last;

  logic [MW-1:0]                  m_in;
  logic                           no_more;

  logic                           div_start;
  logic [MW-1:0]                  div_q;
  logic [MW-1:0]                  div_r;
  dcs_pkg::unit_status_t          div_stat;

  logic                           mul_start;
  logic [MUL_W-1:0]               mul_a;
  logic [MUL_W-1:0]               mul_b;
  logic [MUL_W-1:0]               mul_limit;
  logic [MUL_W-1:0]               mul_p;
  dcs_pkg::unit_status_t          mul_stat;

  assign m_in    = value[MW-1:0];
  assign no_more = sq > {2'b00, m};

  dcs_div #(.W(MW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (m),
    .divisor   (d),
    .quotient  (div_q),
    .remainder (div_r),
    .status    (div_stat)
  );

  dcs_mul #(.W(MUL_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .limit   (mul_limit),
    .product (mul_p),
    .status  (mul_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dcs_pkg::S_IDLE: begin
        if (start) begin
          state_next = (m_in == '0) ? dcs_pkg::S_DONE : dcs_pkg::S_CHECK;
        end
      end
      dcs_pkg::S_CHECK: begin
        if (no_more) begin
          state_next = (m > MW'(1)) ? dcs_pkg::S_CNT_MUL : dcs_pkg::S_DONE;
        end else begin
          state_next = dcs_pkg::S_DIV;
        end
      end
      dcs_pkg::S_DIV:      state_next = dcs_pkg::S_DIV_WAIT;
      dcs_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          if (div_r == '0) begin
            state_next = dcs_pkg::S_PK_MUL;
          end else if (e1 > EW'(1)) begin
            state_next = dcs_pkg::S_CNT_MUL;
          end else begin
            state_next = dcs_pkg::S_NEXT;
          end
        end
      end
      dcs_pkg::S_PK_MUL:   state_next = dcs_pkg::S_PK_WAIT;
      dcs_pkg::S_PK_WAIT: begin
        if (mul_stat.done) begin
          state_next = dcs_pkg::S_DIV;
        end
      end
      dcs_pkg::S_CNT_MUL:  state_next = dcs_pkg::S_CNT_WAIT;
      dcs_pkg::S_CNT_WAIT: begin
        if (mul_stat.done) begin
          state_next = dcs_pkg::S_SUM_MUL;
        end
      end
      dcs_pkg::S_SUM_MUL:  state_next = dcs_pkg::S_SUM_WAIT;
      dcs_pkg::S_SUM_WAIT: begin
        if (mul_stat.done) begin
          state_next = last ? dcs_pkg::S_DONE : dcs_pkg::S_NEXT;
        end
      end
      dcs_pkg::S_NEXT:     state_next = dcs_pkg::S_CHECK;
      dcs_pkg::S_DONE:     state_next = dcs_pkg::S_IDLE;
      default:             state_next = dcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = state != dcs_pkg::S_IDLE;
    done      = state == dcs_pkg::S_DONE;
    div_start = state == dcs_pkg::S_DIV;
    mul_start = state inside {dcs_pkg::S_PK_MUL, dcs_pkg::S_CNT_MUL, dcs_pkg::S_SUM_MUL};
    case (state)
      dcs_pkg::S_CNT_MUL: begin
        mul_a     = MUL_W'(count);
        mul_b     = MUL_W'(e1);
        mul_limit = dcs_pkg::COUNT_MAX;
      end
      dcs_pkg::S_SUM_MUL: begin
        mul_a     = MUL_W'(sum);
        mul_b     = MUL_W'(s);
        mul_limit = dcs_pkg::SUM_MAX;
      end
      default: begin
        mul_a     = pk;
        mul_b     = MUL_W'(d);
        mul_limit = dcs_pkg::SUM_MAX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (state == dcs_pkg::S_IDLE && start) begin
      last <= 1'b0;
    end else if (state == dcs_pkg::S_CHECK && no_more && m > MW'(1)) begin
      last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dcs_pkg::S_IDLE: begin
        if (start) begin
          m     <= m_in;
          d     <= MW'(2);
          sq    <= (MW+2)'(4);
          e1    <= EW'(1);
          pk    <= MUL_W'(1);
          s     <= (MW+1)'(1);
          count <= dcs_pkg::COUNT_W'(m_in != '0);
          sum   <= dcs_pkg::SUM_W'(m_in != '0);
        end
      end
      dcs_pkg::S_CHECK: begin
        if (no_more && m > MW'(1)) begin
          e1 <= EW'(2);
          s  <= {1'b0, m} + (MW+1)'(1);
        end
      end
      dcs_pkg::S_DIV_WAIT: begin
        if (div_stat.done && div_r == '0) begin
          m  <= div_q;
          e1 <= e1 + EW'(1);
        end
      end
      dcs_pkg::S_PK_WAIT: begin
        if (mul_stat.done) begin
          pk <= mul_p;
          s  <= s + mul_p[MW:0];
        end
      end
      dcs_pkg::S_CNT_WAIT: begin
        if (mul_stat.done) begin
          count <= mul_p[dcs_pkg::COUNT_W-1:0];
        end
      end
      dcs_pkg::S_SUM_WAIT: begin
        if (mul_stat.done) begin
          sum <= mul_p[dcs_pkg::SUM_W-1:0];
        end
      end
      dcs_pkg::S_NEXT: begin
        if (d == MW'(2)) begin
          d  <= MW'(3);
          sq <= (MW+2)'(9);
        end else begin
          d  <= d + MW'(2);
          sq <= sq + {d, 2'b00} + (MW+2)'(4);
        end
        e1 <= EW'(1);
        pk <= MUL_W'(1);
        s  <= (MW+1)'(1);
      end
      default: begin
      end
    endcase
  end

  assign divisor_count = count;
  assign divisor_sum   = sum;

endmodule

`default_nettype wire

// ===== rtl/dcs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module dcs_div #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [W-1:0]          dividend,
  input  wire logic [W-1:0]          divisor,
  output logic [W-1:0]               quotient,
  output logic [W-1:0]               remainder,
  output dcs_pkg::unit_status_t      status
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic          run;
  logic          fin;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[W-1]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
        rem <= '0;
        quo <= dividend;
      end else if (run) begin
        rem <= rem_next;
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = run;
  assign status.done = fin;

endmodule

`default_nettype wire

// ===== rtl/dcs_mul.sv =====
// Bit-serial saturating multiplier, multiplier bits taken MSB first.
`default_nettype none

module dcs_mul #(
  parameter int W = 36
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [W-1:0]          a,
  input  wire logic [W-1:0]          b,
  input  wire logic [W-1:0]          limit,
  output logic [W-1:0]               product,
  output dcs_pkg::unit_status_t      status
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  lim_r;
  logic          sat;
  logic          run;
  logic          fin;

  logic [W+1:0]  tot;
  logic          over;

  always_comb begin
    tot  = {1'b0, acc, 1'b0} + {2'b00, (b_r[W-1] ? a_r : {W{1'b0}})};
    over = tot > {2'b00, lim_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CW'(W);
        acc   <= '0;
        sat   <= 1'b0;
        a_r   <= a;
        b_r   <= b;
        lim_r <= limit;
      end else if (run) begin
        b_r <= {b_r[W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (sat || over) begin
          sat <= 1'b1;
          acc <= lim_r;
        end else begin
          acc <= tot[W-1:0];
        end
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign product     = acc;
  assign status.busy = run;
  assign status.done = fin;

endmodule

`default_nettype wire

// ===== rtl/dcs_check.sv =====
// Port-level checks for the divisor count and sum block, with its bind.
`default_nettype none

module dcs_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] value,
  input wire logic        done,
  input wire logic [10:0] divisor_count,
  input wire logic [35:0] divisor_sum
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but busy did not rise");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block did not return to idle after result");

  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    done |-> ((divisor_count == 11'd0) == (divisor_sum == 36'd0)))
    else $error("count and sum disagree on the zero case");

  a_accept_value: assert property (@(posedge clk) disable iff (rst)
    start && !busy && value[0] |=> !done)
    else $error("odd request finished without any trial");

endmodule

bind divisor_count_and_sum dcs_check u_dcs_check (.*);

`default_nettype wire
